FILE: rtl/particle_grid_blend_step_top_macros.svh
// Assertion macros for the particle grid blend step.
// Used by the top level only; needs a clock named clk and a reset named rst.
`ifndef PARTICLE_GRID_BLEND_STEP_TOP_MACROS_SVH
`define PARTICLE_GRID_BLEND_STEP_TOP_MACROS_SVH

// plain property, checked out of reset
`define PGBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition now implies a consequence in the next cycle
`define PGBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pgbs_pkg.sv
// Shared types and command codes for the particle grid blend step.
// No dependencies.
package pgbs_pkg;

  localparam logic [1:0] CMD_CLEAR   = 2'd0;
  localparam logic [1:0] CMD_SCATTER = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic [15:0] COUNT_FULL = 16'hFFFF;

  typedef struct packed {
    logic signed [31:0] sum_vx;
    logic signed [31:0] sum_vy;
    logic [15:0]        count;
  } cell_t;

endpackage

FILE: rtl/pgbs_grid_mem.sv
// Grid cell store: one write port, one registered read port.
// Depends on pgbs_pkg for the cell word.
module pgbs_grid_mem #(
  parameter int DEPTH = 65536,
  parameter int AW = 16
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pgbs_pkg::cell_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output pgbs_pkg::cell_t rdata
);

  pgbs_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/pgbs_div.sv
// Bit-serial signed divider: 32 bit sum by 16 bit count, truncating.
// One quotient bit per cycle; no dependencies.
module pgbs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [15:0]        divisor,
  output logic               busy,
  output logic signed [16:0] quot
);

  logic [31:0] q;
  logic [15:0] rem;
  logic [15:0] den;
  logic        neg;
  logic [4:0]  cnt;
  logic [16:0] sh;
  logic [16:0] diff;
  logic        ge;
  logic [16:0] qs;

  assign sh   = {rem, q[31]};
  assign ge   = sh >= {1'b0, den};
  assign diff = sh - {1'b0, den};
  assign qs   = neg ? (~q[16:0] + 17'd1) : q[16:0];
  assign quot = signed'(qs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd31;
    end else if (busy) begin
      cnt <= cnt - 5'd1;
      if (cnt == 5'd0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend[31] ? (~dividend + 32'd1) : dividend;
      neg <= dividend[31];
      den <= divisor;
      rem <= '0;
    end else if (busy) begin
      q   <= {q[30:0], ge};
      rem <= ge ? diff[15:0] : sh[15:0];
    end
  end

endmodule

FILE: rtl/particle_grid_blend_step_top.sv
// Particle grid blend step, top level. Items are taken one at a time. A clear
// sweeps the grid memory one cell per cycle, and the same sweep runs after
// reset; no item is taken during it. A scatter is accepted, addressed, then
// read and written back; one outside the grid ends after the address step.
// An update in the grid reads its cell, waits on the bit-serial divider that
// forms the cell average if the cell is non-empty, and blends; every update
// then adds gravity, moves and checks the walls. The result sits in an
// output register, so the next item can be taken while it waits. Depends on
// pgbs_pkg, pgbs_grid_mem, pgbs_div and the assertion macro header.
`include "particle_grid_blend_step_top_macros.svh"

module particle_grid_blend_step_top #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] new_x,
  output logic signed [23:0] new_y,
  output logic signed [15:0] new_vx,
  output logic signed [15:0] new_vy,
  output logic               cell_hit,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CELLS = GRID_COLS * GRID_ROWS;
  localparam int AW = $clog2(CELLS);

  localparam logic [2:0] REG_GRAVITY  = 3'd0;
  localparam logic [2:0] REG_BLEND    = 3'd1;
  localparam logic [2:0] REG_BOUNCE   = 3'd2;
  localparam logic [2:0] REG_FRICTION = 3'd3;
  localparam logic [2:0] REG_RIGHT    = 3'd4;
  localparam logic [2:0] REG_BOTTOM   = 3'd5;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_ADDR  = 10'b0000000100,
    S_READ  = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_BLEND = 10'b0000100000,
    S_GRAV  = 10'b0001000000,
    S_MOVE  = 10'b0010000000,
    S_WALLX = 10'b0100000000,
    S_WALLY = 10'b1000000000
  } state_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] rnd_sat(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = (v + 32'sd128) >>> 8;
    return sat16(t);
  endfunction

  function automatic logic signed [9:0] fac(input logic [8:0] r);
    return r[8] ? 10'sd256 : signed'({1'b0, r});
  endfunction

  state_t state;

  logic signed [15:0] gravity;
  logic [8:0]         blend_weight;
  logic [8:0]         wall_damping;
  logic [8:0]         floor_friction;
  logic [9:0]         right_limit;
  logic [9:0]         bottom_limit;

  logic [1:0]         cmd_r;
  logic signed [23:0] px_r;
  logic signed [23:0] py_r;
  logic signed [15:0] vx_r;
  logic signed [15:0] vy_r;
  logic [AW-1:0]      idx_r;
  logic               hit_r;
  logic signed [16:0] avg_x;
  logic signed [16:0] avg_y;
  logic signed [24:0] px25;
  logic signed [24:0] py25;
  logic signed [23:0] nx_r;
  logic [AW-1:0]      clr_cnt;

  // cell lookup
  logic               x_ok;
  logic               y_ok;
  logic [14:0]        cx;
  logic [14:0]        cy;
  logic [31:0]        idx_full;
  logic [AW-1:0]      idx_calc;

  assign x_ok = px_r[23] ? ((px_r[23:8] == 16'hFFFF) && (px_r[7:0] != 8'd0))
                         : ({17'd0, px_r[22:8]} < 32'(GRID_COLS));
  assign y_ok = py_r[23] ? ((py_r[23:8] == 16'hFFFF) && (py_r[7:0] != 8'd0))
                         : ({17'd0, py_r[22:8]} < 32'(GRID_ROWS));
  assign cx = px_r[23] ? 15'd0 : px_r[22:8];
  assign cy = py_r[23] ? 15'd0 : py_r[22:8];
  assign idx_full = 32'({17'd0, cy}) * 32'(GRID_COLS) + 32'({17'd0, cx});
  assign idx_calc = idx_full[AW-1:0];

  // memory
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  pgbs_pkg::cell_t mem_wdata;
  pgbs_pkg::cell_t mem_rdata;
  pgbs_pkg::cell_t scat_cell;
  logic            scat_we;

  assign scat_cell.sum_vx = mem_rdata.sum_vx + 32'(vx_r);
  assign scat_cell.sum_vy = mem_rdata.sum_vy + 32'(vy_r);
  assign scat_cell.count  = mem_rdata.count + 16'd1;
  assign scat_we = (state == S_READ) && (cmd_r == pgbs_pkg::CMD_SCATTER)
                   && (mem_rdata.count != pgbs_pkg::COUNT_FULL);
  assign mem_we    = (state == S_CLEAR) || scat_we;
  assign mem_waddr = (state == S_CLEAR) ? clr_cnt : idx_r;
  assign mem_wdata = (state == S_CLEAR) ? '0 : scat_cell;

  pgbs_grid_mem #(.DEPTH(CELLS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (state == S_ADDR),
    .raddr (idx_calc),
    .rdata (mem_rdata)
  );

  // dividers
  logic               div_start;
  logic               div_busy;
  logic               div_busy_y;
  logic signed [16:0] qx;
  logic signed [16:0] qy;

  assign div_start = (state == S_READ) && (cmd_r == pgbs_pkg::CMD_UPDATE)
                     && (mem_rdata.count != 16'd0);

  pgbs_div u_div_x (
    .clk (clk), .rst (rst), .start (div_start),
    .dividend (mem_rdata.sum_vx), .divisor (mem_rdata.count),
    .busy (div_busy), .quot (qx)
  );

  pgbs_div u_div_y (
    .clk (clk), .rst (rst), .start (div_start),
    .dividend (mem_rdata.sum_vy), .divisor (mem_rdata.count),
    .busy (div_busy_y), .quot (qy)
  );

  // blend
  logic signed [9:0]  w;
  logic signed [9:0]  wc;
  logic signed [27:0] bl_x;
  logic signed [27:0] bl_y;

  assign w    = fac(blend_weight);
  assign wc   = 10'sd256 - w;
  assign bl_x = w * vx_r + wc * avg_x;
  assign bl_y = w * vy_r + wc * avg_y;

  // walls
  logic signed [9:0]  dmp;
  logic signed [9:0]  fri;
  logic signed [24:0] xmax;
  logic signed [24:0] ymax;
  logic signed [16:0] nvx;
  logic signed [16:0] nvy;
  logic signed [27:0] bx;
  logic signed [27:0] by;
  logic signed [27:0] fx;
  logic               out_free;

  assign dmp  = fac(wall_damping);
  assign fri  = fac(floor_friction);
  assign xmax = signed'({7'd0, right_limit, 8'd0});
  assign ymax = signed'({7'd0, bottom_limit, 8'd0});
  assign nvx  = -{vx_r[15], vx_r};
  assign nvy  = -{vy_r[15], vy_r};
  assign bx   = nvx * dmp;
  assign by   = nvy * dmp;
  assign fx   = vx_r * fri;
  assign out_free = !out_valid || !out_stall;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity        <= 16'sd77;
      blend_weight   <= 9'd230;
      wall_damping   <= 9'd102;
      floor_friction <= 9'd205;
      right_limit    <= 10'd255;
      bottom_limit   <= 10'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAVITY:  gravity        <= signed'(cfg_data);
        REG_BLEND:    blend_weight   <= cfg_data[8:0];
        REG_BOUNCE:   wall_damping   <= cfg_data[8:0];
        REG_FRICTION: floor_friction <= cfg_data[8:0];
        REG_RIGHT:    right_limit    <= cfg_data[9:0];
        REG_BOTTOM:   bottom_limit   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          unique case (cmd_r)
            pgbs_pkg::CMD_CLEAR: begin
              clr_cnt <= '0;
              state   <= S_CLEAR;
            end
            pgbs_pkg::CMD_SCATTER: state <= (x_ok && y_ok) ? S_READ : S_IDLE;
            pgbs_pkg::CMD_UPDATE:  state <= (x_ok && y_ok) ? S_READ : S_GRAV;
            pgbs_pkg::CMD_NONE:    state <= S_IDLE;
            default:               state <= S_IDLE;
          endcase
        end
        S_READ: begin
          if (cmd_r == pgbs_pkg::CMD_SCATTER) begin
            state <= S_IDLE;
          end else if (mem_rdata.count != 16'd0) begin
            state <= S_DIV;
          end else begin
            state <= S_BLEND;
          end
        end
        S_DIV: begin
          if (!div_busy) begin
            state <= S_BLEND;
          end
        end
        S_BLEND: state <= S_GRAV;
        S_GRAV:  state <= S_MOVE;
        S_MOVE:  state <= S_WALLX;
        S_WALLX: state <= S_WALLY;
        S_WALLY: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r <= cmd;
          px_r  <= pos_x;
          py_r  <= pos_y;
          vx_r  <= vel_x;
          vy_r  <= vel_y;
        end
      end
      S_ADDR: begin
        idx_r <= idx_calc;
        hit_r <= x_ok && y_ok;
      end
      S_READ: begin
        avg_x <= '0;
        avg_y <= '0;
      end
      S_DIV: begin
        if (!div_busy) begin
          avg_x <= qx;
          avg_y <= qy;
        end
      end
      S_BLEND: begin
        vx_r <= rnd_sat(32'(bl_x));
        vy_r <= rnd_sat(32'(bl_y));
      end
      S_GRAV: begin
        vy_r <= sat16(32'(vy_r) + 32'(gravity));
      end
      S_MOVE: begin
        px25 <= 25'(px_r) + 25'(vx_r);
        py25 <= 25'(py_r) + 25'(vy_r);
      end
      S_WALLX: begin
        if (px25 < 25'sd0) begin
          nx_r <= '0;
          vx_r <= rnd_sat(32'(bx));
        end else if (px25 > xmax) begin
          nx_r <= xmax[23:0];
          vx_r <= rnd_sat(32'(bx));
        end else begin
          nx_r <= px25[23:0];
        end
      end
      S_WALLY: begin
        if (out_free) begin
          new_x    <= nx_r;
          cell_hit <= hit_r;
          new_vx   <= vx_r;
          if (py25 < 25'sd0) begin
            new_y  <= '0;
            new_vy <= rnd_sat(32'(by));
          end else if (py25 > ymax) begin
            new_y  <= ymax[23:0];
            new_vy <= rnd_sat(32'(by));
            new_vx <= rnd_sat(32'(fx));
          end else begin
            new_y  <= py25[23:0];
            new_vy <= vy_r;
          end
        end
      end
      default: ;
    endcase
  end

  `PGBS_ASSERT(a_div_in_wait, div_busy |-> (state == S_DIV), "divider busy outside wait")
  `PGBS_ASSERT(a_div_lanes, div_busy == div_busy_y, "divider lanes out of step")
  `PGBS_ASSERT(a_no_full_write, scat_we |-> (mem_rdata.count != pgbs_pkg::COUNT_FULL), "write to full cell")
  `PGBS_ASSERT(a_out_source, $rose(out_valid) |-> ($past(state) == S_WALLY), "result from wrong state")
  `PGBS_ASSERT_NEXT(a_div_starts, div_start, div_busy, "divider did not start")

endmodule

FILE: dv/particle_grid_blend_step_top_tb.sv
// Self-checking testbench for particle_grid_blend_step_top: a cycle-free
// predictor of the grid and the particle step, random valid/stall traffic.
// Depends on pgbs_pkg and the top level RTL.
`timescale 1ns / 1ps

module particle_grid_blend_step_top_tb;

  localparam int COLS = 256;
  localparam int ROWS = 256;
  localparam logic [2:0] REG_GRAVITY  = 3'd0;
  localparam logic [2:0] REG_BLEND    = 3'd1;
  localparam logic [2:0] REG_DAMPING  = 3'd2;
  localparam logic [2:0] REG_FRICTION = 3'd3;
  localparam logic [2:0] REG_RIGHT    = 3'd4;
  localparam logic [2:0] REG_BOTTOM   = 3'd5;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic               hit;
  } particle_t;

  class particle_step_model;
    int        sum_vx[int];
    int        sum_vy[int];
    int        count[int];
    longint    gravity, blend, damping, friction, right_lim, bottom_lim;
    particle_t pending_particles[$];
    int        errors, checked, n_scatter, n_update, n_clear;

    function new();
      gravity = 77; blend = 230; damping = 102; friction = 205;
      right_lim = 255; bottom_lim = 255;
    endfunction

    function void configure(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_GRAVITY:  gravity    = longint'($signed(val));
        REG_BLEND:    blend      = val[8:0];
        REG_DAMPING:  damping    = val[8:0];
        REG_FRICTION: friction   = val[8:0];
        REG_RIGHT:    right_lim  = val[9:0];
        REG_BOTTOM:   bottom_lim = val[9:0];
        default: ;
      endcase
    endfunction

    function longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function longint rnd8(longint v);
      return (v + 128) >>> 8;
    endfunction

    function longint clip256(longint r);
      return r > 256 ? 256 : r;
    endfunction

    function void note_accepted(logic [1:0] c, logic signed [23:0] px_i,
                                logic signed [23:0] py_i, logic signed [15:0] vx_i,
                                logic signed [15:0] vy_i);
      longint px, py, vx, vy, cx, cy, n, ax, ay, w, d, f;
      int idx;
      bit hit;
      particle_t e;
      px = px_i; py = py_i; vx = vx_i; vy = vy_i;
      cx = px / 256; cy = py / 256;
      hit = cx >= 0 && cx < COLS && cy >= 0 && cy < ROWS;
      idx = int'(cy * COLS + cx);
      case (c)
        pgbs_pkg::CMD_CLEAR: begin
          sum_vx.delete(); sum_vy.delete(); count.delete();
          n_clear++;
        end
        pgbs_pkg::CMD_SCATTER: begin
          n_scatter++;
          if (hit) begin
            if (!count.exists(idx)) begin
              count[idx] = 0; sum_vx[idx] = 0; sum_vy[idx] = 0;
            end
            if (count[idx] != 65535) begin
              sum_vx[idx] = sum_vx[idx] + vx;
              sum_vy[idx] = sum_vy[idx] + vy;
              count[idx]  = count[idx] + 1;
            end
          end
        end
        pgbs_pkg::CMD_UPDATE: begin
          n_update++;
          if (hit) begin
            n = count.exists(idx) ? count[idx] : 0;
            ax = 0; ay = 0;
            w = clip256(blend);
            if (n > 0) begin
              ax = longint'(sum_vx[idx]) / n;
              ay = longint'(sum_vy[idx]) / n;
            end
            vx = sat16(rnd8(w * vx + (256 - w) * ax));
            vy = sat16(rnd8(w * vy + (256 - w) * ay));
          end
          vy = sat16(vy + gravity);
          px += vx; py += vy;
          d = clip256(damping); f = clip256(friction);
          if (px < 0) begin
            px = 0; vx = sat16(rnd8(-vx * d));
          end else if (px > right_lim * 256) begin
            px = right_lim * 256; vx = sat16(rnd8(-vx * d));
          end
          if (py < 0) begin
            py = 0; vy = sat16(rnd8(-vy * d));
          end else if (py > bottom_lim * 256) begin
            py = bottom_lim * 256; vy = sat16(rnd8(-vy * d));
            vx = sat16(rnd8(vx * f));
          end
          e.x = px[23:0]; e.y = py[23:0]; e.vx = vx[15:0]; e.vy = vy[15:0];
          e.hit = hit;
          pending_particles.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_emitted(particle_t got);
      particle_t e;
      if (pending_particles.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d vx=%0d vy=%0d hit=%0d",
                 $time, got.x, got.y, got.vx, got.vy, got.hit);
        errors++;
        return;
      end
      e = pending_particles.pop_front();
      checked++;
      if (got !== e) begin
        $display("%0t: mismatch exp x=%0d y=%0d vx=%0d vy=%0d hit=%0d", $time,
                 e.x, e.y, e.vx, e.vy, e.hit);
        $display("%0t:          got x=%0d y=%0d vx=%0d vy=%0d hit=%0d", $time,
                 got.x, got.y, got.vx, got.vy, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         cmd = pgbs_pkg::CMD_NONE;
  logic signed [23:0] pos_x = '0;
  logic signed [23:0] pos_y = '0;
  logic signed [15:0] vel_x = '0;
  logic signed [15:0] vel_y = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [23:0] new_x;
  logic signed [23:0] new_y;
  logic signed [15:0] new_vx;
  logic signed [15:0] new_vy;
  logic               cell_hit;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;

  particle_step_model sb = new();
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int rx_idle = 0;
  int n_settings = 0;

  particle_grid_blend_step_top #(.GRID_COLS(COLS), .GRID_ROWS(ROWS)) i_dut (
    .clk, .rst, .in_valid, .in_stall, .cmd, .pos_x, .pos_y, .vel_x, .vel_y,
    .out_valid, .out_stall, .new_x, .new_y, .new_vx, .new_vy, .cell_hit,
    .cfg_we, .cfg_index, .cfg_data
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #(64'd50_000_000);
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: check transfers, random stall bursts, one long hold on request
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_emitted({new_x, new_y, new_vx, new_vy, cell_hit});
    if (rx_idle > 0) begin
      out_stall <= 1'b1;
      rx_idle--;
    end else if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_idle = 399;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rx_idle = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(logic [1:0] c, logic signed [23:0] px, logic signed [23:0] py,
                      logic signed [15:0] vx, logic signed [15:0] vy);
    in_valid <= 1'b1;
    cmd <= c; pos_x <= px; pos_y <= py; vel_x <= vx; vel_y <= vy;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_accepted(c, px, py, vx, vy);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_particles.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic apply_setting(logic [15:0] g, logic [15:0] b, logic [15:0] d,
                               logic [15:0] f, logic [15:0] r, logic [15:0] bt);
    logic [15:0] vals[6];
    vals = '{g, b, d, f, r, bt};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1; cfg_index <= 3'(i); cfg_data <= vals[i];
      @(posedge clk);
      sb.configure(3'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic logic signed [23:0] in_cell(int c);
    return 24'(c * 256 + int'($urandom_range(0, 255)));
  endfunction

  function automatic logic signed [15:0] rand_vel();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4095)) - 2048);
  endfunction

  // mostly scatters and updates on a few hot cells, some walls and noise
  task automatic random_item(output bit counted);
    int k, cx, cy;
    logic signed [23:0] px, py;
    k = $urandom_range(0, 99);
    cx = ($urandom_range(0, 4) == 0) ? $urandom_range(250, 255) : $urandom_range(0, 3);
    cy = ($urandom_range(0, 4) == 0) ? $urandom_range(250, 255) : $urandom_range(0, 3);
    px = in_cell(cx); py = in_cell(cy);
    counted = 1'b1;
    if (k < 45) send(pgbs_pkg::CMD_SCATTER, px, py, rand_vel(), rand_vel());
    else if (k < 82) send(pgbs_pkg::CMD_UPDATE, px, py, rand_vel(), rand_vel());
    else if (k < 88)
      send($urandom_range(0, 1) ? pgbs_pkg::CMD_UPDATE : pgbs_pkg::CMD_SCATTER,
           24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom));
    else if (k < 96) begin
      px = 24'(sb.right_lim * 256 + int'($urandom_range(0, 1023)) - 512);
      py = 24'(sb.bottom_lim * 256 + int'($urandom_range(0, 1023)) - 512);
      if ($urandom_range(0, 1)) px = 24'(int'($urandom_range(0, 511)) - 256);
      if ($urandom_range(0, 1)) py = 24'(int'($urandom_range(0, 511)) - 256);
      send(pgbs_pkg::CMD_UPDATE, px, py, rand_vel(), rand_vel());
    end else begin
      send(pgbs_pkg::CMD_NONE, 24'($urandom), 24'($urandom), 16'($urandom),
           16'($urandom));
      counted = 1'b0;
    end
  endtask

  initial begin
    bit counted;
    int done;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);

    // directed: empty grid, extremes, fractional negative cell, walls, clear
    send(pgbs_pkg::CMD_UPDATE, 24'sd1000, 24'sd1000, 16'sd100, -16'sd100);
    send(pgbs_pkg::CMD_SCATTER, 24'sd10, 24'sd20, 16'sh7FFF, 16'sh7FFF);
    send(pgbs_pkg::CMD_SCATTER, 24'sd30, 24'sd40, 16'sh7FFF, -16'sh8000);
    send(pgbs_pkg::CMD_UPDATE, 24'sd5, 24'sd5, 16'sh7FFF, 16'sh7FFF);
    send(pgbs_pkg::CMD_SCATTER, -24'sd100, -24'sd1, -16'sh8000, 16'sd300);
    send(pgbs_pkg::CMD_UPDATE, -24'sd255, 24'sd100, -16'sh8000, -16'sh8000);
    send(pgbs_pkg::CMD_UPDATE, 24'sh7FFFFF, 24'sh7FFFFF, 16'sh7FFF, 16'sh7FFF);
    send(pgbs_pkg::CMD_UPDATE, -24'sh800000, -24'sh800000, -16'sh8000, -16'sh8000);
    send(pgbs_pkg::CMD_SCATTER, 24'sd65535, 24'sd65535, 16'sd1, -16'sd1);
    send(pgbs_pkg::CMD_UPDATE, 24'sd65535, 24'sd65535, 16'sd0, 16'sd0);
    send(pgbs_pkg::CMD_UPDATE, 24'sd65536, 24'sd100, 16'sd0, 16'sd0);
    send(pgbs_pkg::CMD_UPDATE, 24'sd300, 24'sd65400, 16'sd2000, 16'sd3000);
    send(pgbs_pkg::CMD_UPDATE, 24'sd300, 24'sd50, -16'sd2000, -16'sd3000);
    send(pgbs_pkg::CMD_NONE, 24'sh7FFFFF, -24'sh800000, 16'shFFFF, 16'sh7FFF);
    send(pgbs_pkg::CMD_CLEAR, 24'sd0, 24'sd0, 16'sd0, 16'sd0);
    send(pgbs_pkg::CMD_UPDATE, 24'sd10, 24'sd20, 16'sd50, 16'sd50);

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0: apply_setting(16'h8000, 16'd0, 16'd256, 16'd0, 16'd0, 16'd0);
        1: apply_setting(16'h7FFF, 16'd256, 16'd0, 16'd256, 16'd1023, 16'd1023);
        2: apply_setting(16'($urandom), 16'h01FF, 16'h01FF, 16'h01FF, 16'd3, 16'd5);
        3: apply_setting(16'($urandom_range(0, 200)), 16'($urandom_range(0, 256)),
                         16'($urandom_range(0, 256)), 16'($urandom_range(0, 256)),
                         16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
        default: apply_setting(16'd77, 16'd230, 16'd102, 16'd205, 16'd255, 16'd255);
      endcase
      if (p == 2)
        send(pgbs_pkg::CMD_CLEAR, 24'($urandom), 24'($urandom), 16'($urandom),
             16'($urandom));
      quiet = (p == 4);
      done = 0;
      while (done < 160) begin
        if (p == 1 && done == 60) begin
          long_hold_req = 1'b1;
          for (int i = 0; i < 12; i++)
            send(pgbs_pkg::CMD_UPDATE, in_cell(1), in_cell(1), rand_vel(), rand_vel());
        end
        if (p == 3 && done == 80) drain();
        random_item(counted);
        if (counted) done++;
      end
    end
    in_valid <= 1'b0;

    done = 0;
    while (sb.pending_particles.size() != 0 && done < 200000) begin
      @(posedge clk);
      done++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d scatters, %0d updates, %0d clears over %0d register settings",
             sb.n_scatter, sb.n_update, sb.n_clear, n_settings);
    $display("%0d results checked, %0d errors", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending_particles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
